// ===== rtl/mbac_pkg.sv =====
`default_nettype none

package mbac_pkg;

    // item kinds carried in the slave tuser
    localparam logic [1:0] OP_WR_PLAYER   = 2'd0;
    localparam logic [1:0] OP_WR_OBSTACLE = 2'd1;
    localparam logic [1:0] OP_CHECK       = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PLAYER_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_PLAYER_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RUN_COUNT     = 2'd2;
    localparam logic [1:0] CFG_DUCK_SLOT     = 2'd3;

    // configuration reset values
    localparam logic [7:0] RST_PLAYER_WIDTH  = 8'd44;
    localparam logic [7:0] RST_PLAYER_HEIGHT = 8'd47;
    localparam logic [2:0] RST_RUN_COUNT     = 3'd6;
    localparam logic [2:0] RST_DUCK_SLOT     = 3'd7;

    // stream widths
    localparam int IN_TDATA_W  = 72;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // coordinate arithmetic width, holds every sum exactly
    localparam int CW = 16;

    typedef logic signed [CW-1:0] t_crd;

    // one stored relative box
    typedef struct packed {
        logic signed [10:0] x;
        logic signed [10:0] y;
        logic [9:0]         w;
        logic [9:0]         h;
    } t_box;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic start;
        logic issue;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_check;
        logic outer_hit;
        logic empty;
        logic last;
        logic hit;
    } t_sts;

    // strict overlap of two boxes
    function automatic logic overlap(input t_crd ax, input t_crd ay,
                                     input t_crd aw, input t_crd ah,
                                     input t_crd bx, input t_crd by,
                                     input t_crd bw, input t_crd bh);
        overlap = (ax < bx + bw) && (ax + aw > bx) &&
                  (ay < by + bh) && (ay + ah > by);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mbac_dpath.sv =====
`default_nettype none

module mbac_dpath
    import mbac_pkg::*;
#(
    parameter int PLAYER_BOX_SLOTS   = 8,
    parameter int OBSTACLE_BOX_SLOTS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    input  wire logic [1:0]            i_operation,
    input  wire logic [3:0]            i_box_index,
    input  wire logic signed [10:0]    i_box_x,
    input  wire logic signed [10:0]    i_box_y,
    input  wire logic [9:0]            i_box_w,
    input  wire logic [9:0]            i_box_h,
    input  wire logic signed [10:0]    i_player_x,
    input  wire logic signed [10:0]    i_player_y,
    input  wire logic                  i_player_ducking,
    input  wire logic [2:0]            i_obstacle_size,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PIW = (PLAYER_BOX_SLOTS > 1) ? $clog2(PLAYER_BOX_SLOTS) : 1;
    localparam int OIW = (OBSTACLE_BOX_SLOTS > 1) ? $clog2(OBSTACLE_BOX_SLOTS) : 1;
    localparam int PCW = $clog2(PLAYER_BOX_SLOTS + 1);
    localparam int OCW = $clog2(OBSTACLE_BOX_SLOTS + 1);

    // configuration registers
    logic [7:0] r_pw;
    logic [7:0] r_ph;
    logic [2:0] r_rbc;
    logic [2:0] r_dslot;

    // box tables
    t_box r_pmem [PLAYER_BOX_SLOTS];
    t_box r_omem [OBSTACLE_BOX_SLOTS];

    // captured check operands
    t_crd         r_px, r_py, r_ox, r_oy, r_ow, r_oh;
    logic [PIW-1:0] r_pfirst;
    logic [PCW-1:0] r_pcount;
    logic [OCW-1:0] r_ocount;

    // pair walk
    logic [PIW-1:0] r_pi;
    logic [PCW-1:0] r_pleft;
    logic [OIW-1:0] r_oi;
    t_box           r_prd;
    t_box           r_ord;
    logic           r_tvld;

    logic [12:0]    c_prod;
    logic [4:0]     c_dslot5;
    logic           c_dvalid;
    logic [PCW-1:0] c_pcount;
    logic [PIW-1:0] c_pfirst;
    logic [OCW-1:0] c_ocount;
    logic [OCW-1:0] c_odec;
    logic [OIW-1:0] c_olast;
    logic           c_owrap;
    t_crd           c_pw, c_ph;
    t_crd           c_ax, c_ay, c_aw, c_ah, c_bx, c_by, c_bw, c_bh;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw    <= RST_PLAYER_WIDTH;
            r_ph    <= RST_PLAYER_HEIGHT;
            r_rbc   <= RST_RUN_COUNT;
            r_dslot <= RST_DUCK_SLOT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PLAYER_WIDTH:  r_pw    <= i_cfg_data;
                CFG_PLAYER_HEIGHT: r_ph    <= i_cfg_data;
                CFG_RUN_COUNT:     r_rbc   <= i_cfg_data[2:0];
                CFG_DUCK_SLOT:     r_dslot <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // table writes on a write transfer, slots past the depth dropped
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture && i_operation == OP_WR_PLAYER &&
            {1'b0, i_box_index} < 5'(PLAYER_BOX_SLOTS)) begin
            r_pmem[i_box_index[PIW-1:0]] <= '{x: i_box_x, y: i_box_y,
                                              w: i_box_w, h: i_box_h};
        end
        if (i_cmd.capture && i_operation == OP_WR_OBSTACLE &&
            {1'b0, i_box_index} < 5'(OBSTACLE_BOX_SLOTS)) begin
            r_omem[i_box_index[OIW-1:0]] <= '{x: i_box_x, y: i_box_y,
                                              w: i_box_w, h: i_box_h};
        end
    end

    // player box range and obstacle count
    always_comb begin
        c_prod   = i_box_w * i_obstacle_size;
        c_dslot5 = {2'b00, r_dslot};
        c_dvalid = c_dslot5 < 5'(PLAYER_BOX_SLOTS);
        if (i_player_ducking) begin
            c_pfirst = c_dslot5[PIW-1:0];
            c_pcount = c_dvalid ? PCW'(1) : '0;
        end else begin
            c_pfirst = '0;
            c_pcount = ({2'b00, r_rbc} > 5'(PLAYER_BOX_SLOTS)) ?
                       PCW'(PLAYER_BOX_SLOTS) : PCW'(r_rbc);
        end
        c_ocount = ({1'b0, i_box_index} > 5'(OBSTACLE_BOX_SLOTS)) ?
                   OCW'(OBSTACLE_BOX_SLOTS) : OCW'(i_box_index);
    end

    // capture check operands, positions shifted by one pixel
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px     <= {{(CW-11){i_player_x[10]}}, i_player_x} + t_crd'(1);
            r_py     <= {{(CW-11){i_player_y[10]}}, i_player_y} + t_crd'(1);
            r_ox     <= {{(CW-11){i_box_x[10]}}, i_box_x} + t_crd'(1);
            r_oy     <= {{(CW-11){i_box_y[10]}}, i_box_y} + t_crd'(1);
            r_ow     <= $signed({{(CW-13){1'b0}}, c_prod}) - t_crd'(2);
            r_oh     <= $signed({{(CW-10){1'b0}}, i_box_h}) - t_crd'(2);
            r_pfirst <= c_pfirst;
            r_pcount <= c_pcount;
            r_ocount <= c_ocount;
        end
    end

    // outer box test
    assign c_pw = $signed({{(CW-8){1'b0}}, r_pw}) - t_crd'(2);
    assign c_ph = $signed({{(CW-8){1'b0}}, r_ph}) - t_crd'(2);

    // pair walk position
    assign c_odec  = r_ocount - OCW'(1);
    assign c_olast = c_odec[OIW-1:0];
    assign c_owrap = (r_oi == c_olast);

    // walk counters and registered table reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvld <= 1'b0;
        end else begin
            r_tvld <= i_cmd.issue;
        end
        if (i_cmd.start) begin
            r_pi    <= r_pfirst;
            r_pleft <= r_pcount;
            r_oi    <= '0;
        end else if (i_cmd.issue) begin
            if (c_owrap) begin
                r_oi    <= '0;
                r_pi    <= r_pi + PIW'(1);
                r_pleft <= r_pleft - PCW'(1);
            end else begin
                r_oi <= r_oi + OIW'(1);
            end
        end
        if (i_cmd.issue) begin
            r_prd <= r_pmem[r_pi];
            r_ord <= r_omem[r_oi];
        end
    end

    // absolute boxes of the pair under test
    always_comb begin
        c_ax = {{(CW-11){r_prd.x[10]}}, r_prd.x} + r_px;
        c_ay = {{(CW-11){r_prd.y[10]}}, r_prd.y} + r_py;
        c_aw = $signed({{(CW-10){1'b0}}, r_prd.w});
        c_ah = $signed({{(CW-10){1'b0}}, r_prd.h});
        c_bx = {{(CW-11){r_ord.x[10]}}, r_ord.x} + r_ox;
        c_by = {{(CW-11){r_ord.y[10]}}, r_ord.y} + r_oy;
        c_bw = $signed({{(CW-10){1'b0}}, r_ord.w});
        c_bh = $signed({{(CW-10){1'b0}}, r_ord.h});
    end

    // status
    always_comb begin
        o_sts.in_check  = (i_operation == OP_CHECK);
        o_sts.outer_hit = overlap(r_px, r_py, c_pw, c_ph, r_ox, r_oy, r_ow, r_oh);
        o_sts.empty     = (r_pcount == '0) || (r_ocount == '0);
        o_sts.last      = (r_pleft == PCW'(1)) && c_owrap;
        o_sts.hit       = r_tvld &&
                          overlap(c_ax, c_ay, c_aw, c_ah, c_bx, c_by, c_bw, c_bh);
    end

endmodule

`default_nettype wire

// ===== rtl/mbac_ctrl.sv =====
`default_nettype none

module mbac_ctrl
    import mbac_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    output logic      o_m_tvalid,
    input  wire logic i_m_tready,
    output logic      o_collision,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_OUTER  = 3'd1;
    localparam logic [2:0] S_PAIR   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_res, n_res;
    logic       r_ovld, n_ovld;
    logic       r_ocol, n_ocol;
    logic       c_in_xfer;
    logic       c_out_free;

    assign o_s_tready  = (r_state == S_IDLE);
    assign c_in_xfer   = i_s_tvalid && o_s_tready;
    assign c_out_free  = !r_ovld || i_m_tready;
    assign o_m_tvalid  = r_ovld;
    assign o_collision = r_ocol;

    // datapath commands
    always_comb begin
        o_cmd.capture = c_in_xfer;
        o_cmd.start   = (r_state == S_OUTER);
        o_cmd.issue   = (r_state == S_PAIR);
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        n_ovld  = r_ovld;
        n_ocol  = r_ocol;
        if (r_ovld && i_m_tready) begin
            n_ovld = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (c_in_xfer) begin
                    n_res   = 1'b0;
                    n_state = i_sts.in_check ? S_OUTER : S_FINISH;
                end
            end
            S_OUTER: begin
                n_res   = 1'b0;
                n_state = (i_sts.outer_hit && !i_sts.empty) ? S_PAIR : S_FINISH;
            end
            S_PAIR: begin
                if (i_sts.hit) begin
                    n_res   = 1'b1;
                    n_state = S_FINISH;
                end else if (i_sts.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_res   = i_sts.hit;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (c_out_free) begin
                    n_ovld  = 1'b1;
                    n_ocol  = r_res;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
        end
        r_res  <= n_res;
        r_ocol <= n_ocol;
    end

endmodule

`default_nettype wire

// ===== rtl/multi_box_aabb_collision.sv =====
// Two-level box collision test for a player sprite against one obstacle.
// Slave stream: tuser carries the item kind (write player box, write
// obstacle box, check); tdata carries the item fields. One item is taken
// at a time: tready is high only while the block is idle.
// Master stream: one transfer per item, tdata bit 0 is the collision flag
// (always 0 for writes and for the unused kind).
// Config channel: index and data, always ready; the user must write it
// only while idle; the block does not enforce this.
// A write goes from input transfer straight to the finish state; a check
// whose outer boxes miss passes the outer test state only; otherwise the
// outer test is followed by a walk of at most P*O pairs, where P is the
// player box count and O the obstacle box count, one box pair per cycle
// through the registered table reads, stopping early on the first hit.
// The input reopens as the result is loaded into the output register.
// A finished result sits in the output register; the next input item is
// accepted while it waits. If the receiver stalls with a result still
// pending, the next finished item holds until the register frees.
// Reset clears the controller and output valid and loads the configuration
// defaults; box table entries hold nothing defined until written.

`default_nettype none

module multi_box_aabb_collision
    import mbac_pkg::*;
#(
    parameter int PLAYER_BOX_SLOTS   = 8,
    parameter int OBSTACLE_BOX_SLOTS = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // box_index, box_x, box_y, box_w, box_h, player_x, player_y,
    // player_ducking, obstacle_size
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // operation
    input  wire logic [IN_TUSER_W-1:0]  i_s_tuser,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // collision, zero fill
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cmd c_cmd;
    t_sts c_sts;
    logic c_collision;

    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {{(OUT_TDATA_W-1){1'b0}}, c_collision};

    // sequencing and output register
    mbac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_collision (c_collision),
        .o_cmd       (c_cmd),
        .i_sts       (c_sts)
    );

    // tables, operands and compare logic
    mbac_dpath #(
        .PLAYER_BOX_SLOTS   (PLAYER_BOX_SLOTS),
        .OBSTACLE_BOX_SLOTS (OBSTACLE_BOX_SLOTS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (c_cmd),
        .o_sts            (c_sts),
        .i_operation      (i_s_tuser[1:0]),
        .i_box_index      (i_s_tdata[3:0]),
        .i_box_x          (i_s_tdata[14:4]),
        .i_box_y          (i_s_tdata[25:15]),
        .i_box_w          (i_s_tdata[35:26]),
        .i_box_h          (i_s_tdata[45:36]),
        .i_player_x       (i_s_tdata[56:46]),
        .i_player_y       (i_s_tdata[67:57]),
        .i_player_ducking (i_s_tdata[68]),
        .i_obstacle_size  (i_s_tdata[71:69]),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

endmodule

`default_nettype wire

// ===== rtl/mbac_checker.sv =====
`default_nettype none

module mbac_checker
    import mbac_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   o_s_tready,
    input  wire logic                   o_m_tvalid,
    input  wire logic                   i_m_tready,
    input  wire logic [OUT_TDATA_W-1:0] o_m_tdata
);

    // reset empties the output register
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output dropped while stalled");

    // one item in flight: input closes right after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken twice in a row");

    // result fill bits stay zero
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[OUT_TDATA_W-1:1] == '0)
        else $error("nonzero fill in result");

endmodule

bind multi_box_aabb_collision mbac_checker u_mbac_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
